// File: rtl/rename_tag_register_file_core_defines.svh
// assertion macros shared by the rename tag register file rtl
`ifndef RENAME_TAG_REGISTER_FILE_CORE_DEFINES_SVH
`define RENAME_TAG_REGISTER_FILE_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define RTRF_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define RTRF_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: rtl/rtrf_pkg.sv
// shared types and constants of the rename tag register file
`timescale 1ns / 1ps

package rtrf_pkg;

  localparam int INDEX_W = 5;
  localparam int VALUE_W = 64;
  localparam int TAG_W   = 4;

  localparam int REGISTER_COUNT_DEFAULT = 16;

  // slave tdata layout, lowest bit first
  localparam int S_FIRST_INDEX_LSB   = 0;
  localparam int S_SECOND_INDEX_LSB  = S_FIRST_INDEX_LSB + INDEX_W;
  localparam int S_FLUSH_BIT         = S_SECOND_INDEX_LSB + INDEX_W;
  localparam int S_COMMIT_EN_BIT     = S_FLUSH_BIT + 1;
  localparam int S_COMMIT_REG_LSB    = S_COMMIT_EN_BIT + 1;
  localparam int S_COMMIT_VALUE_LSB  = S_COMMIT_REG_LSB + INDEX_W;
  localparam int S_COMMIT_TAG_LSB    = S_COMMIT_VALUE_LSB + VALUE_W;
  localparam int S_ISSUE_EN_BIT      = S_COMMIT_TAG_LSB + TAG_W;
  localparam int S_ISSUE_REG_LSB     = S_ISSUE_EN_BIT + 1;
  localparam int S_ISSUE_TAG_LSB     = S_ISSUE_REG_LSB + INDEX_W;
  localparam int S_USED_W            = S_ISSUE_TAG_LSB + TAG_W;
  localparam int S_TDATA_W           = ((S_USED_W + 7) / 8) * 8;

  // master tdata layout: one port result is value, tag, tag valid
  localparam int M_PORT_W  = VALUE_W + TAG_W + 1;
  localparam int M_USED_W  = 2 * M_PORT_W;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

  typedef struct packed {
    logic               flush;
    logic               commit_enable;
    logic [INDEX_W-1:0] commit_register;
    logic [VALUE_W-1:0] commit_value;
    logic [TAG_W-1:0]   commit_tag;
    logic               issue_enable;
    logic [INDEX_W-1:0] issue_register;
    logic [TAG_W-1:0]   issue_tag;
  } update_t;

  typedef struct packed {
    logic             tag_valid;
    logic [TAG_W-1:0] tag;
  } status_rd_t;

endpackage

// File: rtl/rtrf_status.sv
// rename status: tag valid bits, tags for commit matching, tag store for the read ports
`timescale 1ns / 1ps

`include "rename_tag_register_file_core_defines.svh"

module rtrf_status #(
  parameter int REGISTER_COUNT = rtrf_pkg::REGISTER_COUNT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  rtrf_pkg::update_t            upd,
  input  logic [rtrf_pkg::INDEX_W-1:0] first_index,
  input  logic [rtrf_pkg::INDEX_W-1:0] second_index,
  output rtrf_pkg::status_rd_t         first_rd,
  output rtrf_pkg::status_rd_t         second_rd
);

  localparam int IW    = rtrf_pkg::INDEX_W;
  localparam int TW    = rtrf_pkg::TAG_W;
  localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [IW:0] COUNT_LIM = (IW + 1)'(REGISTER_COUNT);

  logic [REGISTER_COUNT-1:0] valid;
  logic [REGISTER_COUNT-1:0] valid_next;
  logic [TW-1:0]             tag_flop [REGISTER_COUNT];
  logic [TW-1:0]             tag_mem  [REGISTER_COUNT];

  logic          first_in_range;
  logic          second_in_range;
  logic          issue_write;
  logic          rd_first_valid;
  logic          rd_second_valid;
  logic [TW-1:0] rd_first_tag;
  logic [TW-1:0] rd_second_tag;

  assign first_in_range  = {1'b0, first_index} < COUNT_LIM;
  assign second_in_range = {1'b0, second_index} < COUNT_LIM;
  assign issue_write     = accept && !upd.flush && upd.issue_enable &&
                           ({1'b0, upd.issue_register} < COUNT_LIM);

  // issue wins over a commit to the same register
  always_comb begin
    valid_next = valid;
    if (accept) begin
      if (upd.flush) begin
        valid_next = '0;
      end else begin
        for (int r = 0; r < REGISTER_COUNT; r++) begin
          if (upd.issue_enable && upd.issue_register == IW'(r)) begin
            valid_next[r] = 1'b1;
          end else if (upd.commit_enable && upd.commit_register == IW'(r) &&
                       valid[r] && tag_flop[r] == upd.commit_tag) begin
            valid_next[r] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      rd_first_valid  <= 1'b0;
      rd_second_valid <= 1'b0;
    end else begin
      valid <= valid_next;
      if (accept) begin
        rd_first_valid  <= first_in_range && valid[first_index[IDX_W-1:0]];
        rd_second_valid <= second_in_range && valid[second_index[IDX_W-1:0]];
      end
    end
  end

  // per-entry copy of the tags, compared in place against the committing entry
  always_ff @(posedge clk) begin
    for (int r = 0; r < REGISTER_COUNT; r++) begin
      if (accept && !upd.flush && upd.issue_enable && upd.issue_register == IW'(r)) begin
        tag_flop[r] <= upd.issue_tag;
      end
    end
  end

  // read-before-write: reads return the tags from before this transaction
  always_ff @(posedge clk) begin
    if (issue_write) begin
      tag_mem[upd.issue_register[IDX_W-1:0]] <= upd.issue_tag;
    end
    if (accept) begin
      rd_first_tag  <= tag_mem[first_index[IDX_W-1:0]];
      rd_second_tag <= tag_mem[second_index[IDX_W-1:0]];
    end
  end

  assign first_rd.tag_valid  = rd_first_valid;
  assign first_rd.tag        = rd_first_valid ? rd_first_tag : '0;
  assign second_rd.tag_valid = rd_second_valid;
  assign second_rd.tag       = rd_second_valid ? rd_second_tag : '0;

  `RTRF_ASSERT_NEXT(a_flush_clears, accept && upd.flush, valid == '0, "flush left a tag valid")
  `RTRF_ASSERT_NEXT(a_issue_sets, issue_write, $countones(valid) != 0, "issue set no tag valid")
  `RTRF_ASSERT_NOW(a_first_no_tag, !first_rd.tag_valid, first_rd.tag == '0, "tag without valid")

endmodule

// File: rtl/rtrf_values.sv
// committed register values with per-entry written bits
`timescale 1ns / 1ps

module rtrf_values #(
  parameter int REGISTER_COUNT = rtrf_pkg::REGISTER_COUNT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  rtrf_pkg::update_t            upd,
  input  logic [rtrf_pkg::INDEX_W-1:0] first_index,
  input  logic [rtrf_pkg::INDEX_W-1:0] second_index,
  output logic [rtrf_pkg::VALUE_W-1:0] first_value,
  output logic [rtrf_pkg::VALUE_W-1:0] second_value
);

  localparam int IW    = rtrf_pkg::INDEX_W;
  localparam int VW    = rtrf_pkg::VALUE_W;
  localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [IW:0] COUNT_LIM = (IW + 1)'(REGISTER_COUNT);

  logic [VW-1:0]             value_mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] written;

  logic          commit_write;
  logic          rd_first_ok;
  logic          rd_second_ok;
  logic [VW-1:0] rd_first_value;
  logic [VW-1:0] rd_second_value;

  assign commit_write = accept && !upd.flush && upd.commit_enable &&
                        ({1'b0, upd.commit_register} < COUNT_LIM);

  // an entry never written reads as its reset value of zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written      <= '0;
      rd_first_ok  <= 1'b0;
      rd_second_ok <= 1'b0;
    end else begin
      if (commit_write) begin
        written[upd.commit_register[IDX_W-1:0]] <= 1'b1;
      end
      if (accept) begin
        rd_first_ok  <= ({1'b0, first_index} < COUNT_LIM) &&
                        written[first_index[IDX_W-1:0]];
        rd_second_ok <= ({1'b0, second_index} < COUNT_LIM) &&
                        written[second_index[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_write) begin
      value_mem[upd.commit_register[IDX_W-1:0]] <= upd.commit_value;
    end
    if (accept) begin
      rd_first_value  <= value_mem[first_index[IDX_W-1:0]];
      rd_second_value <= value_mem[second_index[IDX_W-1:0]];
    end
  end

  assign first_value  = rd_first_ok ? rd_first_value : '0;
  assign second_value = rd_second_ok ? rd_second_value : '0;

endmodule

// File: rtl/rename_tag_register_file_core.sv
// top level of the rename tag register file: stream ports, result register
//
//   channel    | direction | carries
//   -----------+-----------+------------------------------------------------
//   s_*        | in        | two read indices, flush, one commit, one issue
//   m_*        | out       | value, tag and tag valid for both read ports
//
// one transaction per cycle while s_tready is high; its result appears the cycle after acceptance
// reads and the commit/issue updates share one clock edge, reads see old state
// the result register drains while the next transaction is taken
// s_tready drops only while a result waits and m_tready is low
// synchronous reset clears all tag valid bits and makes every stored value read as zero
`timescale 1ns / 1ps

`include "rename_tag_register_file_core_defines.svh"

module rename_tag_register_file_core #(
  parameter int REGISTER_COUNT = rtrf_pkg::REGISTER_COUNT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // first_index, second_index, flush, commit_enable, commit_register,
  // commit_value, commit_tag, issue_enable, issue_register, issue_tag, zero pad
  input  logic [rtrf_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // first_value, first_tag, first_tag_valid, second_value, second_tag,
  // second_tag_valid, zero pad
  output logic [rtrf_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int IW = rtrf_pkg::INDEX_W;
  localparam int VW = rtrf_pkg::VALUE_W;
  localparam int TW = rtrf_pkg::TAG_W;

  logic                 accept;
  rtrf_pkg::update_t    upd;
  logic [IW-1:0]        first_index;
  logic [IW-1:0]        second_index;
  rtrf_pkg::status_rd_t first_rd;
  rtrf_pkg::status_rd_t second_rd;
  logic [VW-1:0]        first_stored;
  logic [VW-1:0]        second_stored;
  logic [VW-1:0]        first_value;
  logic [VW-1:0]        second_value;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign first_index         = s_tdata[rtrf_pkg::S_FIRST_INDEX_LSB +: IW];
  assign second_index        = s_tdata[rtrf_pkg::S_SECOND_INDEX_LSB +: IW];
  assign upd.flush           = s_tdata[rtrf_pkg::S_FLUSH_BIT];
  assign upd.commit_enable   = s_tdata[rtrf_pkg::S_COMMIT_EN_BIT];
  assign upd.commit_register = s_tdata[rtrf_pkg::S_COMMIT_REG_LSB +: IW];
  assign upd.commit_value    = s_tdata[rtrf_pkg::S_COMMIT_VALUE_LSB +: VW];
  assign upd.commit_tag      = s_tdata[rtrf_pkg::S_COMMIT_TAG_LSB +: TW];
  assign upd.issue_enable    = s_tdata[rtrf_pkg::S_ISSUE_EN_BIT];
  assign upd.issue_register  = s_tdata[rtrf_pkg::S_ISSUE_REG_LSB +: IW];
  assign upd.issue_tag       = s_tdata[rtrf_pkg::S_ISSUE_TAG_LSB +: TW];

  rtrf_status #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_status (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .upd         (upd),
    .first_index (first_index),
    .second_index(second_index),
    .first_rd    (first_rd),
    .second_rd   (second_rd)
  );

  rtrf_values #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_values (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .upd         (upd),
    .first_index (first_index),
    .second_index(second_index),
    .first_value (first_stored),
    .second_value(second_stored)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // a renamed register shows its tag and a zero value
  assign first_value  = first_rd.tag_valid ? '0 : first_stored;
  assign second_value = second_rd.tag_valid ? '0 : second_stored;

  assign m_tdata = {{rtrf_pkg::M_PAD_W{1'b0}},
                    second_rd.tag_valid, second_rd.tag, second_value,
                    first_rd.tag_valid, first_rd.tag, first_value};

  `RTRF_ASSERT_NOW(a_backpressure, m_tvalid && !m_tready, !s_tready, "accepted while stalled")
  `RTRF_ASSERT_NEXT(a_result_follows, accept, m_tvalid, "no result after a transaction")
  `RTRF_ASSERT_NOW(a_renamed_zero, first_rd.tag_valid, first_value == '0, "renamed value not zero")
  `RTRF_ASSERT_NOW(a_plain_no_tag, !second_rd.tag_valid, second_rd.tag == '0, "tag without valid")

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the rename tag register file core
`timescale 1ns / 1ps

module tb_top;

  localparam int IW          = rtrf_pkg::INDEX_W;
  localparam int VW          = rtrf_pkg::VALUE_W;
  localparam int TW          = rtrf_pkg::TAG_W;
  localparam int SW          = rtrf_pkg::S_TDATA_W;
  localparam int MW          = rtrf_pkg::M_TDATA_W;
  localparam int PW          = rtrf_pkg::M_PORT_W;
  localparam int RF_DEPTH    = rtrf_pkg::REGISTER_COUNT_DEFAULT;
  localparam int RAND_ITEMS  = 450;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_SHOWN   = 10;
  localparam int DRAIN_WAIT  = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [IW-1:0]     first_index;
    logic [IW-1:0]     second_index;
    rtrf_pkg::update_t upd;
  } rf_op_t;

  typedef struct {
    logic [VW-1:0] value;
    logic [TW-1:0] tag;
    logic          tag_valid;
  } port_read_t;

  typedef struct {
    port_read_t first;
    port_read_t second;
  } read_pair_t;

  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [SW-1:0] s_tdata  = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [MW-1:0] m_tdata;

  rename_tag_register_file_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // architectural state as the predictor sees it
  logic [VW-1:0] shadow_values  [RF_DEPTH];
  logic [TW-1:0] shadow_tags    [RF_DEPTH];
  logic          shadow_renamed [RF_DEPTH];

  // last tag issued per register, used to aim commits at live renames
  logic [TW-1:0] issued_tag [1 << IW];

  rf_op_t     stim_q[$];
  read_pair_t reads_due_q[$];
  rf_op_t     driven_op;
  idle_mode_t idle_mode = IDLE_NONE;
  bit         s_fire = 1'b0;
  bit         m_fire = 1'b0;
  int         errors = 0;
  int         items_in = 0;
  int         results_out = 0;
  int         flush_cnt = 0;
  int         tag_clear_cnt = 0;
  int         renamed_reads = 0;
  int         oor_reads = 0;
  int         quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic port_read_t lookup_port(logic [IW-1:0] idx);
    port_read_t r;
    r = '{value: '0, tag: '0, tag_valid: 1'b0};
    if (idx >= RF_DEPTH) begin
      oor_reads++;
    end else if (shadow_renamed[idx]) begin
      r.tag       = shadow_tags[idx];
      r.tag_valid = 1'b1;
      renamed_reads++;
    end else begin
      r.value = shadow_values[idx];
    end
    return r;
  endfunction

  // one transaction of the register file: reads first, then flush or commit and issue
  function automatic read_pair_t regfile_cycle(rf_op_t op);
    read_pair_t rd;
    rd.first  = lookup_port(op.first_index);
    rd.second = lookup_port(op.second_index);
    if (op.upd.flush) begin
      foreach (shadow_renamed[r]) shadow_renamed[r] = 1'b0;
      flush_cnt++;
    end else begin
      if (op.upd.commit_enable && op.upd.commit_register < RF_DEPTH) begin
        shadow_values[op.upd.commit_register] = op.upd.commit_value;
        if (shadow_renamed[op.upd.commit_register] &&
            shadow_tags[op.upd.commit_register] == op.upd.commit_tag) begin
          shadow_renamed[op.upd.commit_register] = 1'b0;
          tag_clear_cnt++;
        end
      end
      if (op.upd.issue_enable && op.upd.issue_register < RF_DEPTH) begin
        shadow_tags[op.upd.issue_register]    = op.upd.issue_tag;
        shadow_renamed[op.upd.issue_register] = 1'b1;
      end
    end
    return rd;
  endfunction

  function automatic logic [SW-1:0] pack_op(rf_op_t op);
    logic [SW-1:0] d;
    d = '0;
    d[rtrf_pkg::S_FIRST_INDEX_LSB +: IW]  = op.first_index;
    d[rtrf_pkg::S_SECOND_INDEX_LSB +: IW] = op.second_index;
    d[rtrf_pkg::S_FLUSH_BIT]              = op.upd.flush;
    d[rtrf_pkg::S_COMMIT_EN_BIT]          = op.upd.commit_enable;
    d[rtrf_pkg::S_COMMIT_REG_LSB +: IW]   = op.upd.commit_register;
    d[rtrf_pkg::S_COMMIT_VALUE_LSB +: VW] = op.upd.commit_value;
    d[rtrf_pkg::S_COMMIT_TAG_LSB +: TW]   = op.upd.commit_tag;
    d[rtrf_pkg::S_ISSUE_EN_BIT]           = op.upd.issue_enable;
    d[rtrf_pkg::S_ISSUE_REG_LSB +: IW]    = op.upd.issue_register;
    d[rtrf_pkg::S_ISSUE_TAG_LSB +: TW]    = op.upd.issue_tag;
    return d;
  endfunction

  function automatic read_pair_t unpack_reads(logic [MW-1:0] d);
    read_pair_t r;
    r.first.value      = d[0 +: VW];
    r.first.tag        = d[VW +: TW];
    r.first.tag_valid  = d[VW + TW];
    r.second.value     = d[PW +: VW];
    r.second.tag       = d[PW + VW +: TW];
    r.second.tag_valid = d[PW + VW + TW];
    return r;
  endfunction

  function automatic rf_op_t make_op(int fi, int si, bit fl, bit ce, int cr,
                                     logic [VW-1:0] cv, int ct,
                                     bit ie, int ir, int it);
    rf_op_t op;
    op.first_index         = IW'(fi);
    op.second_index        = IW'(si);
    op.upd.flush           = fl;
    op.upd.commit_enable   = ce;
    op.upd.commit_register = IW'(cr);
    op.upd.commit_value    = cv;
    op.upd.commit_tag      = TW'(ct);
    op.upd.issue_enable    = ie;
    op.upd.issue_register  = IW'(ir);
    op.upd.issue_tag       = TW'(it);
    return op;
  endfunction

  function automatic logic [IW-1:0] pick_reg();
    if ($urandom_range(99) < 85) return IW'($urandom_range(RF_DEPTH - 1));
    return IW'($urandom_range((1 << IW) - 1));
  endfunction

  function automatic rf_op_t random_op();
    rf_op_t op;
    op.first_index         = pick_reg();
    op.second_index        = pick_reg();
    op.upd.flush           = ($urandom_range(99) < 3);
    op.upd.commit_enable   = ($urandom_range(99) < 60);
    op.upd.commit_register = pick_reg();
    op.upd.commit_value    = {$urandom(), $urandom()};
    op.upd.commit_tag      = ($urandom_range(99) < 60) ? issued_tag[op.upd.commit_register]
                                                       : TW'($urandom());
    op.upd.issue_enable    = ($urandom_range(99) < 50);
    op.upd.issue_register  = pick_reg();
    op.upd.issue_tag       = TW'($urandom());
    if (op.upd.issue_enable && !op.upd.flush)
      issued_tag[op.upd.issue_register] = op.upd.issue_tag;
    return op;
  endfunction

  task automatic note_mismatch(string what, logic [VW-1:0] want,
                               logic [VW-1:0] got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("mismatch on %s, result %0d: expected %h, got %h",
               what, results_out, want, got);
  endtask

  task automatic compare_port(string port, port_read_t want, port_read_t got);
    if (got.value !== want.value) note_mismatch({port, " value"}, want.value, got.value);
    if (got.tag !== want.tag) note_mismatch({port, " tag"}, want.tag, got.tag);
    if (got.tag_valid !== want.tag_valid)
      note_mismatch({port, " tag valid"}, want.tag_valid, got.tag_valid);
  endtask

  // driver: new transaction or idle decided at the falling edge
  always @(negedge clk) begin : drive_proc
    int send_gap_pct;
    int stall_pct;
    send_gap_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    stall_pct    = (idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (!s_tvalid || s_fire) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          driven_op = stim_q.pop_front();
          s_tdata  <= pack_op(driven_op);
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: handshakes at the rising edge, results checked in order
  always @(posedge clk) begin : check_proc
    read_pair_t want;
    read_pair_t got;
    s_fire = !rst && s_tvalid && s_tready;
    m_fire = !rst && m_tvalid && m_tready;
    if (m_fire) begin
      got = unpack_reads(m_tdata);
      results_out++;
      if (reads_due_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected result %0d: %h", results_out, m_tdata);
      end else begin
        want = reads_due_q.pop_front();
        compare_port("first", want.first, got.first);
        compare_port("second", want.second, got.second);
      end
    end
    if (s_fire) begin
      reads_due_q.push_back(regfile_cycle(driven_op));
      items_in++;
    end
    if (s_fire || m_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, reads_due_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus_proc
    idle_mode_t modes[4];
    modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    for (int r = 0; r < RF_DEPTH; r++) begin
      shadow_values[r]  = '0;
      shadow_tags[r]    = '0;
      shadow_renamed[r] = 1'b0;
    end
    foreach (issued_tag[r]) issued_tag[r] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fresh reset, extremes, tag match and mismatch, flush, range edges
    stim_q.push_back(make_op(0, 31, 0, 0, 0, '0, 0, 0, 0, 0));
    stim_q.push_back(make_op(15, 16, 0, 1, 0, '1, 0, 0, 0, 0));
    stim_q.push_back(make_op(0, 0, 0, 1, 15, 64'h8000_0000_0000_0001, 15, 1, 3, 15));
    stim_q.push_back(make_op(3, 15, 0, 1, 3, 64'h5555_5555_5555_5555, 14, 0, 0, 0));
    stim_q.push_back(make_op(3, 3, 0, 1, 3, 64'haaaa_aaaa_aaaa_aaaa, 15, 0, 0, 0));
    stim_q.push_back(make_op(3, 5, 0, 1, 5, 64'h1234_5678_9abc_def0, 0, 1, 5, 7));
    stim_q.push_back(make_op(5, 5, 0, 1, 31, '1, 7, 1, 16, 9));
    stim_q.push_back(make_op(16, 31, 0, 0, 5, 64'hdead_beef, 7, 0, 16, 0));
    stim_q.push_back(make_op(5, 0, 0, 0, 0, '0, 0, 1, 1, 2));
    stim_q.push_back(make_op(1, 5, 0, 0, 0, '0, 0, 1, 2, 9));
    stim_q.push_back(make_op(1, 2, 1, 1, 1, 64'hffff, 2, 1, 4, 3));
    stim_q.push_back(make_op(1, 2, 0, 1, 1, 64'h0f0f_0f0f_0f0f_0f0f, 2, 0, 0, 0));
    stim_q.push_back(make_op(4, 1, 0, 1, 14, '0, 0, 1, 14, 0));
    stim_q.push_back(make_op(14, 5, 0, 1, 14, 64'h7, 0, 1, 14, 15));
    stim_q.push_back(make_op(14, 15, 0, 0, 0, '0, 0, 0, 0, 0));
    stim_q.push_back(make_op(15, 14, 1, 0, 0, '0, 0, 0, 0, 0));
    stim_q.push_back(make_op(14, 15, 0, 1, 15, '1, 8, 1, 15, 8));
    stim_q.push_back(make_op(15, 31, 0, 1, 15, 64'h1, 8, 0, 0, 0));
    stim_q.push_back(make_op(15, 14, 0, 0, 0, '0, 0, 0, 0, 0));

    // each handshake phase starts only after the previous one has fully drained
    foreach (modes[m]) begin
      idle_mode = modes[m];
      repeat (RAND_ITEMS) stim_q.push_back(random_op());
      do begin
        @(posedge clk);
        #1;
      end while (stim_q.size() != 0 || s_tvalid || reads_due_q.size() != 0);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (reads_due_q.size() != 0) begin
      errors += reads_due_q.size();
      $display("%0d expected results never arrived", reads_due_q.size());
    end
    $display("%0d transactions in, %0d results out, %0d mismatches", items_in,
             results_out, errors);
    $display("%0d flushes, %0d tag-clearing commits, %0d renamed reads, %0d out-of-range reads",
             flush_cnt, tag_clear_cnt, renamed_reads, oor_reads);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
